@@ rtl/prd_pkg.sv @@
package prd_pkg;

	// Field widths of the pixel and direction channels.
	localparam int PIX_W = 10;
	localparam int DIR_W = 18;

	// Configuration register widths.
	localparam int SCALE_W = 20;
	localparam int START_W = 24;
	localparam int ENT_W = 20;
	localparam int ROT_W = 3 * ENT_W;
	localparam int CFG_DATA_W = ROT_W;
	localparam int CFG_IDX_W = 3;

	// Default image size.
	localparam int DEF_IMAGE_WIDTH = 1024;
	localparam int DEF_IMAGE_HEIGHT = 1024;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_X = 3'd0,
		REG_SCALE_Y = 3'd1,
		REG_START_X = 3'd2,
		REG_START_Y = 3'd3,
		REG_ROT_ROW0 = 3'd4,
		REG_ROT_ROW1 = 3'd5,
		REG_ROT_ROW2 = 3'd6
	} cfg_reg_t;

	// Reset values: unit scale and an identity matrix (1.0 in Q2.18).
	localparam logic [SCALE_W-1:0] SCALE_RST = 20'h10000;
	localparam logic [ENT_W-1:0] ROT_ONE = 20'h40000;

endpackage

@@ rtl/prd_pix_if.sv @@
interface prd_pix_if import prd_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	modport source(output valid, output pixel_x, output pixel_y, input ready);
	modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ rtl/prd_dir_if.sv @@
interface prd_dir_if import prd_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic signed [DIR_W-1:0] dir_z;

	modport source(output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink(input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

@@ rtl/primary_ray_direction_unit.sv @@
// Pinhole-camera primary ray generator.
// A transaction on the pix channel carries one pixel coordinate; for each one
// a single transaction leaves on the dir channel with the unit ray direction,
// rotated by the camera matrix, as three saturated Q2.16 components.
// Camera scale, start point and matrix rows are written through the plain
// write port (cfg_we, cfg_idx, cfg_wdata); the user must write them only while
// no pixel is in flight, which the block itself does not enforce. The pipeline
// is 35 register stages deep. A new pixel may enter on every cycle unless a
// waiting result is held up by dir.ready low, so the sustained rate is one ray
// per cycle while the receiver keeps up; the depth is set by the square root,
// which retires two result bits per stage over 16 stages, and the three
// dividers, which retire two quotient bits per stage over 9 stages.
// The whole pipeline advances together: when the receiver holds dir.ready
// low with a result waiting, every stage freezes and pix.ready falls, so
// nothing is dropped or repeated. Bubbles travel as stages with the valid
// bit clear.
// Reset clears all valid bits and loads unit scales, a zero start point and
// the identity matrix.
module primary_ray_direction_unit import prd_pkg::*; #(
	parameter int IMAGE_WIDTH = DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
	input logic clk,
	input logic arst_n,
	prd_pix_if.sink pix,
	prd_dir_if.source dir,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Screen mapping widths: the centre offset 2p+1-W fits 14 signed bits for
	// image sizes up to 4096, and its magnitude scaled by 2^16 fits A_W bits.
	localparam int NUM_W = 14;
	localparam int A_W = NUM_W - 1 + 16;
	// Reciprocal of the image size; the product estimate is off by at most one.
	localparam int RCP_K = A_W;
	localparam int RCP_W = A_W;
	localparam logic [RCP_W-1:0] RCP_X = RCP_W'((64'd1 << RCP_K) / IMAGE_WIDTH);
	localparam logic [RCP_W-1:0] RCP_Y = RCP_W'((64'd1 << RCP_K) / IMAGE_HEIGHT);
	localparam int T_W = A_W + NUM_W;
	localparam int SX_W = A_W + 1;
	localparam int SP_W = SX_W + SCALE_W + 1;
	localparam int PX_W = SP_W - 16;
	localparam int D_W = PX_W + 1;
	localparam int MAG_W = 31;
	localparam logic [MAG_W-1:0] CLAMP = MAG_W'(64'd1 << 30);
	localparam int S_W = 2 * MAG_W;
	// Square root: 31 result bits, two per stage.
	localparam int RT_ITER = 31;
	localparam int RT_PER = 2;
	localparam int RT_STG = (RT_ITER + RT_PER - 1) / RT_PER;
	localparam int R_W = 31;
	// Division: 17 quotient bits, two per stage.
	localparam int N_W = MAG_W + 16;
	localparam int Q_W = 17;
	localparam int DV_ITER = Q_W;
	localparam int DV_PER = 2;
	localparam int DV_STG = (DV_ITER + DV_PER - 1) / DV_PER;
	localparam int NV_W = Q_W + 1;
	localparam int P_W = ENT_W + NV_W;
	localparam int ACC_W = P_W + 2;
	localparam int SH_W = ACC_W - 18;
	localparam int NST = 7 + RT_STG + 1 + DV_STG + 2;

	typedef struct packed {
		logic [S_W-1:0] rem;
		logic [S_W-1:0] res;
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic neg_x;
		logic neg_y;
	} rt_t;

	typedef struct packed {
		logic [N_W-1:0] rem;
		logic [Q_W-1:0] q;
	} dv_lane_t;

	typedef struct packed {
		logic [R_W-1:0] r;
		dv_lane_t [2:0] ln;
		logic neg_x;
		logic neg_y;
	} dv_t;

	// Configuration registers.
	logic [SCALE_W-1:0] scale_x_q, scale_y_q;
	logic signed [START_W-1:0] start_x_q, start_y_q;
	logic [ROT_W-1:0] rot_q [3];

	logic en;
	logic [NST:1] vld_s;

	logic [A_W-1:0] a_x_s1, a_y_s1, a_x_s2, a_y_s2, qe_x_s2, qe_y_s2;
	logic neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2;
	logic signed [SX_W-1:0] sx_s3, sy_s3;
	logic signed [PX_W-1:0] px_s4, py_s4;
	logic [MAG_W-1:0] mag_x_s5, mag_y_s5, mag_x_s6, mag_y_s6;
	logic neg_x_s5, neg_y_s5, neg_x_s6, neg_y_s6;
	logic [S_W-1:0] sq_x_s6, sq_y_s6;
	rt_t rt_s [0:RT_STG];
	dv_t dv_s [0:DV_STG];
	logic signed [P_W-1:0] prod_s34 [3][3];
	logic signed [DIR_W-1:0] dir_s35 [3];

	// One square root step of the bit-pair recurrence.
	function automatic rt_t rt_step(input rt_t x, input int unsigned it);
		logic [S_W-1:0] bit_v;
		logic [S_W-1:0] trial;
		rt_t y;
		bit_v = S_W'(1) << (S_W - 2 - 2 * it);
		trial = x.res + bit_v;
		y = x;
		if (x.rem >= trial) begin
			y.rem = x.rem - trial;
			y.res = (x.res >> 1) + bit_v;
		end else begin
			y.res = x.res >> 1;
		end
		return y;
	endfunction

	// One restoring division step for quotient bit k.
	function automatic dv_lane_t dv_step(input dv_lane_t x, input logic [R_W-1:0] r,
			input int unsigned k);
		logic [N_W:0] d;
		dv_lane_t y;
		d = (N_W+1)'(r) << k;
		y = x;
		if ({1'b0, x.rem} >= d) begin
			y.rem = x.rem - d[N_W-1:0];
			y.q[k] = 1'b1;
		end
		return y;
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= SCALE_RST;
			scale_y_q <= SCALE_RST;
			start_x_q <= '0;
			start_y_q <= '0;
			rot_q[0] <= {ROT_ONE, {ENT_W{1'b0}}, {ENT_W{1'b0}}};
			rot_q[1] <= {{ENT_W{1'b0}}, ROT_ONE, {ENT_W{1'b0}}};
			rot_q[2] <= {{ENT_W{1'b0}}, {ENT_W{1'b0}}, ROT_ONE};
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_SCALE_X: scale_x_q <= cfg_wdata[SCALE_W-1:0];
				REG_SCALE_Y: scale_y_q <= cfg_wdata[SCALE_W-1:0];
				REG_START_X: start_x_q <= cfg_wdata[START_W-1:0];
				REG_START_Y: start_y_q <= cfg_wdata[START_W-1:0];
				REG_ROT_ROW0: rot_q[0] <= cfg_wdata[ROT_W-1:0];
				REG_ROT_ROW1: rot_q[1] <= cfg_wdata[ROT_W-1:0];
				REG_ROT_ROW2: rot_q[2] <= cfg_wdata[ROT_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves as one unless a finished result is held up.
	assign en = !vld_s[NST] || dir.ready;
	assign pix.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:1], pix.valid};
		end
	end

	// Stage 1: pixel centre offset from the image centre, as a magnitude
	// scaled by 2^16 with half the image size added for rounding.
	logic signed [NUM_W-1:0] num_x, num_y;
	logic [NUM_W-1:0] abs_x, abs_y;

	always_comb begin
		num_x = $signed({3'b000, pix.pixel_x, 1'b1}) - $signed(NUM_W'(IMAGE_WIDTH));
		num_y = $signed(NUM_W'(IMAGE_HEIGHT)) - $signed({3'b000, pix.pixel_y, 1'b1});
		abs_x = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
		abs_y = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_x_s1 <= {abs_x[NUM_W-2:0], 16'h0000} + A_W'(IMAGE_WIDTH / 2);
			a_y_s1 <= {abs_y[NUM_W-2:0], 16'h0000} + A_W'(IMAGE_HEIGHT / 2);
			neg_x_s1 <= num_x[NUM_W-1];
			neg_y_s1 <= num_y[NUM_W-1];
		end
	end

	// Stage 2: quotient estimate by the reciprocal.
	logic [A_W+RCP_W-1:0] rp_x, rp_y;

	always_comb begin
		rp_x = (A_W+RCP_W)'(a_x_s1) * (A_W+RCP_W)'(RCP_X);
		rp_y = (A_W+RCP_W)'(a_y_s1) * (A_W+RCP_W)'(RCP_Y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qe_x_s2 <= rp_x[A_W+RCP_W-1:RCP_K];
			qe_y_s2 <= rp_y[A_W+RCP_W-1:RCP_K];
			a_x_s2 <= a_x_s1;
			a_y_s2 <= a_y_s1;
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
		end
	end

	// Stage 3: correct the estimate by one where the remainder allows it,
	// then restore the sign to give the Q16 screen coordinate.
	logic [T_W-1:0] rm_x, rm_y;
	logic [A_W-1:0] q_x, q_y;

	always_comb begin
		rm_x = T_W'(a_x_s2) - T_W'(qe_x_s2) * T_W'(IMAGE_WIDTH);
		rm_y = T_W'(a_y_s2) - T_W'(qe_y_s2) * T_W'(IMAGE_HEIGHT);
		q_x = qe_x_s2 + A_W'(rm_x >= T_W'(IMAGE_WIDTH));
		q_y = qe_y_s2 + A_W'(rm_y >= T_W'(IMAGE_HEIGHT));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s3 <= neg_x_s2 ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
			sy_s3 <= neg_y_s2 ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
		end
	end

	// Stage 4: scale by the field of view factors, rounded to Q16.
	logic signed [SP_W-1:0] sp_x, sp_y;

	always_comb begin
		sp_x = $signed(sx_s3) * $signed({1'b0, scale_x_q}) + SP_W'(32768);
		sp_y = $signed(sy_s3) * $signed({1'b0, scale_y_q}) + SP_W'(32768);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4 <= sp_x[SP_W-1:16];
			py_s4 <= sp_y[SP_W-1:16];
		end
	end

	// Stage 5: subtract the start point and clamp to plus or minus 2^14 in Q16.
	logic signed [D_W-1:0] d_x, d_y;

	always_comb begin
		d_x = D_W'(px_s4) - D_W'(start_x_q);
		d_y = D_W'(py_s4) - D_W'(start_y_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_s5 <= d_x[D_W-1];
			neg_y_s5 <= d_y[D_W-1];
			if (d_x > $signed(D_W'(CLAMP)) || d_x < -$signed(D_W'(CLAMP))) begin
				mag_x_s5 <= CLAMP;
			end else begin
				mag_x_s5 <= d_x[D_W-1] ? MAG_W'(-d_x) : MAG_W'(d_x);
			end
			if (d_y > $signed(D_W'(CLAMP)) || d_y < -$signed(D_W'(CLAMP))) begin
				mag_y_s5 <= CLAMP;
			end else begin
				mag_y_s5 <= d_y[D_W-1] ? MAG_W'(-d_y) : MAG_W'(d_y);
			end
		end
	end

	// Stage 6: squares.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s6 <= S_W'(mag_x_s5) * S_W'(mag_x_s5);
			sq_y_s6 <= S_W'(mag_y_s5) * S_W'(mag_y_s5);
			mag_x_s6 <= mag_x_s5;
			mag_y_s6 <= mag_y_s5;
			neg_x_s6 <= neg_x_s5;
			neg_y_s6 <= neg_y_s5;
		end
	end

	// Stage 7: squared length; the z component adds 1.0 squared in Q32.
	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0].rem <= sq_x_s6 + sq_y_s6 + (S_W'(1) << 32);
			rt_s[0].res <= '0;
			rt_s[0].mag_x <= mag_x_s6;
			rt_s[0].mag_y <= mag_y_s6;
			rt_s[0].neg_x <= neg_x_s6;
			rt_s[0].neg_y <= neg_y_s6;
		end
	end

	// Stages 8 to 23: integer square root, two result bits per stage.
	for (genvar g = 0; g < RT_STG; g++) begin : g_rt
		rt_t nxt;

		always_comb begin
			nxt = rt_s[g];
			for (int k = 0; k < RT_PER; k++) begin
				if (g * RT_PER + k < RT_ITER) begin
					nxt = rt_step(nxt, g * RT_PER + k);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[g+1] <= nxt;
			end
		end
	end

	// Stage 24: dividends for the three components, with half the length
	// added so that the quotient rounds half away from zero.
	logic [R_W-1:0] len;

	assign len = rt_s[RT_STG].res[R_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].r <= len;
			dv_s[0].ln[0].rem <= {rt_s[RT_STG].mag_x, 16'h0000} + N_W'(len >> 1);
			dv_s[0].ln[1].rem <= {rt_s[RT_STG].mag_y, 16'h0000} + N_W'(len >> 1);
			dv_s[0].ln[2].rem <= (N_W'(1) << 32) + N_W'(len >> 1);
			dv_s[0].ln[0].q <= '0;
			dv_s[0].ln[1].q <= '0;
			dv_s[0].ln[2].q <= '0;
			dv_s[0].neg_x <= rt_s[RT_STG].neg_x;
			dv_s[0].neg_y <= rt_s[RT_STG].neg_y;
		end
	end

	// Stages 25 to 33: three restoring dividers, two quotient bits per stage.
	for (genvar g = 0; g < DV_STG; g++) begin : g_dv
		dv_t nxt;

		always_comb begin
			nxt = dv_s[g];
			for (int k = 0; k < DV_PER; k++) begin
				if (g * DV_PER + k < DV_ITER) begin
					for (int l = 0; l < 3; l++) begin
						nxt.ln[l] = dv_step(nxt.ln[l], nxt.r, Q_W - 1 - (g * DV_PER + k));
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[g+1] <= nxt;
			end
		end
	end

	// Stage 34: signed unit vector times every matrix entry.
	logic signed [NV_W-1:0] nv [3];

	always_comb begin
		nv[0] = dv_s[DV_STG].neg_x ? -$signed({1'b0, dv_s[DV_STG].ln[0].q})
			: $signed({1'b0, dv_s[DV_STG].ln[0].q});
		nv[1] = dv_s[DV_STG].neg_y ? -$signed({1'b0, dv_s[DV_STG].ln[1].q})
			: $signed({1'b0, dv_s[DV_STG].ln[1].q});
		nv[2] = -$signed({1'b0, dv_s[DV_STG].ln[2].q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s34[i][j] <= $signed(rot_q[i][ROT_W-1-ENT_W*j -: ENT_W]) * nv[j];
				end
			end
		end
	end

	// Stage 35: row sums, rounded from Q34 to Q16 and saturated.
	logic signed [ACC_W-1:0] acc [3];
	logic signed [SH_W-1:0] sh [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACC_W'(prod_s34[i][0]) + ACC_W'(prod_s34[i][1])
				+ ACC_W'(prod_s34[i][2]) + ACC_W'(131072);
			sh[i] = acc[i][ACC_W-1:18];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (sh[i] > $signed(SH_W'(131071))) begin
					dir_s35[i] <= DIR_W'(131071);
				end else if (sh[i] < -$signed(SH_W'(131072))) begin
					dir_s35[i] <= DIR_W'(131072);
				end else begin
					dir_s35[i] <= sh[i][DIR_W-1:0];
				end
			end
		end
	end

	assign dir.valid = vld_s[NST];
	assign dir.dir_x = dir_s35[0];
	assign dir.dir_y = dir_s35[1];
	assign dir.dir_z = dir_s35[2];

endmodule

@@ verif/primary_ray_direction_unit_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the primary ray direction unit.
// An initial block builds phases of pixel transactions, all but the pressure phase
// under a camera setting of its own, and a clocked driver feeds them in. A clocked
// monitor takes each direction transaction and compares it with the oldest predicted ray.
module primary_ray_direction_unit_tb;
	import prd_pkg::*;

	localparam int LATENCY = 35;

	typedef struct packed {
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;
	} pixel_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] dx;
		logic signed [DIR_W-1:0] dy;
		logic signed [DIR_W-1:0] dz;
	} ray_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	prd_pix_if pix();
	prd_dir_if dir();

	primary_ray_direction_unit DUT (
		.clk(clk), .arst_n(arst_n), .pix(pix.sink), .dir(dir.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// Camera setting as the predictor sees it.
	logic [SCALE_W-1:0] cam_scale_x, cam_scale_y;
	logic [START_W-1:0] cam_start_x, cam_start_y;
	logic [ROT_W-1:0] cam_row [3];

	pixel_t pending_pixels[$];
	ray_t expected_rays[$];
	int mismatch_count = 0;
	bit send_idle_enable = 1;
	bit recv_idle_enable = 1;
	bit recv_hold = 0;
	int hold_cycles = 0;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Signed division rounded half away from zero; the divisor is positive.
	function automatic longint div_round_away(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	// The >>> operator on a signed longint is a floor shift.
	function automatic longint round_floor_shift(longint v, int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic longint isqrt(longint unsigned s);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	// Predicts the rotated unit direction for one pixel.
	function automatic ray_t trace_direction(pixel_t p);
		longint sx, sy, v[3], nrm[3], r, acc, m;
		longint unsigned sq;
		ray_t res;
		sx = div_round_away((2 * longint'(p.px) + 1 - DEF_IMAGE_WIDTH) * 65536,
			DEF_IMAGE_WIDTH);
		sy = div_round_away((DEF_IMAGE_HEIGHT - (2 * longint'(p.py) + 1)) * 65536,
			DEF_IMAGE_HEIGHT);
		v[0] = round_floor_shift(sx * longint'(cam_scale_x), 16)
			- longint'(signed'(cam_start_x));
		v[1] = round_floor_shift(sy * longint'(cam_scale_y), 16)
			- longint'(signed'(cam_start_y));
		for (int i = 0; i < 2; i++) begin
			if (v[i] > (longint'(1) <<< 30)) v[i] = longint'(1) <<< 30;
			if (v[i] < -(longint'(1) <<< 30)) v[i] = -(longint'(1) <<< 30);
		end
		v[2] = -65536;
		sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
		r = isqrt(sq);
		for (int i = 0; i < 3; i++) nrm[i] = div_round_away(v[i] * 65536, r);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) begin
				m = longint'(signed'(cam_row[i][40 - 20 * j +: ENT_W]));
				acc += m * nrm[j];
			end
			acc = round_floor_shift(acc, 18);
			if (acc > 131071) acc = 131071;
			if (acc < -131072) acc = -131072;
			if (i == 0) res.dx = acc[DIR_W-1:0];
			else if (i == 1) res.dy = acc[DIR_W-1:0];
			else res.dz = acc[DIR_W-1:0];
		end
		return res;
	endfunction

	// Driver: an item counts as sent once its transaction has taken place.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.pixel_x <= '0;
			pix.pixel_y <= '0;
		end else begin
			if (pix.valid && pix.ready) begin
				expected_rays.push_back(trace_direction({pix.pixel_x, pix.pixel_y}));
			end
			if (!pix.valid || pix.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					pix.valid <= 1'b0;
				end else if (send_idle_enable && $urandom_range(0, 15) == 0) begin
					send_gap <= $urandom_range(1, 19);
					pix.valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					pixel_t p;
					p = pending_pixels.pop_front();
					pix.pixel_x <= p.px;
					pix.pixel_y <= p.py;
					pix.valid <= 1'b1;
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver idling.
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir.ready <= 1'b0;
		end else begin
			if (dir.valid && dir.ready) begin
				if (expected_rays.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected ray %0d %0d %0d", dir.dir_x, dir.dir_y, dir.dir_z);
				end else begin
					ray_t e;
					e = expected_rays.pop_front();
					if (e.dx !== dir.dir_x || e.dy !== dir.dir_y || e.dz !== dir.dir_z) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("ray mismatch: expected %0d %0d %0d, got %0d %0d %0d",
								e.dx, e.dy, e.dz, dir.dir_x, dir.dir_y, dir.dir_z);
					end
				end
			end
			// The long hold-off lets the pipeline fill and push back on pixels.
			if (recv_hold) begin
				hold_cycles <= hold_cycles + 1;
				dir.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				dir.ready <= 1'b0;
			end else if (recv_idle_enable && $urandom_range(0, 15) == 0) begin
				recv_gap <= $urandom_range(1, 19);
				dir.ready <= 1'b0;
			end else begin
				dir.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SCALE_X: cam_scale_x = val[SCALE_W-1:0];
			REG_SCALE_Y: cam_scale_y = val[SCALE_W-1:0];
			REG_START_X: cam_start_x = val[START_W-1:0];
			REG_START_Y: cam_start_y = val[START_W-1:0];
			REG_ROT_ROW0: cam_row[0] = val[ROT_W-1:0];
			REG_ROT_ROW1: cam_row[1] = val[ROT_W-1:0];
			default: cam_row[2] = val[ROT_W-1:0];
		endcase
	endtask

	// Waits until every queued pixel has gone in and every ray has come back.
	task automatic drain;
		while (pending_pixels.size() > 0 || pix.valid || expected_rays.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [ENT_W-1:0] rand_entry();
		case ($urandom_range(0, 3))
			0: return 20'h80000;
			1: return 20'h7FFFF;
			2: return $urandom_range(0, 1) ? 20'h40000 : 20'hC0000;
			default: return ENT_W'($urandom());
		endcase
	endfunction

	task automatic random_setting(int style);
		logic [ROT_W-1:0] row;
		write_reg(REG_SCALE_X, CFG_DATA_W'(style == 0 ? 32'd0 : style == 1 ? 32'hFFFFF
			: $urandom_range(0, 20'h3FFFF)));
		write_reg(REG_SCALE_Y, CFG_DATA_W'(style == 0 ? 32'd0 : style == 1 ? 32'hFFFFF
			: $urandom_range(0, 20'h3FFFF)));
		write_reg(REG_START_X, CFG_DATA_W'(style == 1 ? 24'h800000 : style == 0 ? 24'h7FFFFF
			: 24'($signed($urandom_range(0, 20'h3FFFF)) - 20'sh1FFFF)));
		write_reg(REG_START_Y, CFG_DATA_W'(style == 1 ? 32'h7FFFFF : style == 0 ? 32'h800000
			: $urandom()));
		for (int i = 0; i < 3; i++) begin
			row = {rand_entry(), rand_entry(), rand_entry()};
			write_reg(cfg_reg_t'(REG_ROT_ROW0 + i), row);
		end
	endtask

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.px = PIX_W'($urandom());
		p.py = PIX_W'($urandom());
		return p;
	endfunction

	initial begin
		cam_scale_x = SCALE_RST;
		cam_scale_y = SCALE_RST;
		cam_start_x = '0;
		cam_start_y = '0;
		cam_row[0] = {ROT_ONE, 20'h0, 20'h0};
		cam_row[1] = {20'h0, ROT_ONE, 20'h0};
		cam_row[2] = {20'h0, 20'h0, ROT_ONE};
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corners and centre under the reset camera.
		pending_pixels.push_back('{10'd0, 10'd0});
		pending_pixels.push_back('{10'd1023, 10'd1023});
		pending_pixels.push_back('{10'd0, 10'd1023});
		pending_pixels.push_back('{10'd1023, 10'd0});
		pending_pixels.push_back('{10'd511, 10'd512});
		pending_pixels.push_back('{10'd512, 10'd511});
		drain();

		// Zero and full scale with extreme start points: vectors that saturate.
		random_setting(0);
		pending_pixels.push_back('{10'd0, 10'd1023});
		pending_pixels.push_back('{10'd700, 10'd3});
		drain();
		random_setting(1);
		pending_pixels.push_back('{10'd1023, 10'd0});
		pending_pixels.push_back('{10'd0, 10'd1023});
		pending_pixels.push_back('{10'd333, 10'd999});
		drain();

		// Pressure: the receiver holds off while pixels keep coming, then the
		// sender pauses until every ray is back.
		recv_hold = 1;
		for (int i = 0; i < 120; i++) pending_pixels.push_back(rand_pixel());
		wait (hold_cycles >= 200);
		recv_hold = 0;
		drain();

		// Random phases under varied settings; the last has no idling at all.
		for (int ph = 0; ph < 8; ph++) begin
			random_setting(ph == 3 ? 0 : ph == 5 ? 1 : 2);
			if (ph == 7) begin
				send_idle_enable = 0;
				recv_idle_enable = 0;
			end
			for (int i = 0; i < 230; i++) pending_pixels.push_back(rand_pixel());
			drain();
		end

		if (mismatch_count == 0 && expected_rays.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
